@@ src/bitmap_set_insert_filter_scan_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap set block
// Shared helpers for writing clocked concurrent assertions on clk.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SET_INSERT_FILTER_SCAN_DEFINES_SVH
`define BITMAP_SET_INSERT_FILTER_SCAN_DEFINES_SVH

// Assertion that is checked at every clock edge, reset included.
`define BSIFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Assertion that is switched off while reset is held.
`define BSIFS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

@@ src/bsifs_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap set package
// Widths, codes and types shared by the bitmap set block and its checker.
// ----------------------------------------------------------------------------
package bsifs_pkg;

  // Hash space of 2^HASH_BITS values, held as 64-bit words.
  localparam int HASH_BITS  = 20;
  localparam int WORD_BITS  = 64;
  localparam int OFF_BITS   = 6;
  localparam int WIDX_BITS  = HASH_BITS - OFF_BITS;
  localparam int WORD_COUNT = 1 << WIDX_BITS;

  // Field widths of the transactions.
  localparam int CMD_W      = 2;
  localparam int HASH_W     = 20;
  localparam int WIDX_W     = 14;

  // Input tdata layout, lowest bit first.
  localparam int CMD_LSB    = 0;
  localparam int HASH_LSB   = CMD_LSB + CMD_W;
  localparam int WIDX_LSB   = HASH_LSB + HASH_W;
  localparam int IN_BITS    = WIDX_LSB + WIDX_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout: the hash, padded to whole bytes.
  localparam int OUT_TDATA_W = ((HASH_W + 7) / 8) * 8;

  // Bit 63 stands for offset 0 inside a word.
  localparam logic [WORD_BITS-1:0] TOP_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_FILTER = 2'd1,
    CMD_SCAN   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EMIT
  } state_t;

endpackage

@@ src/bitmap_set_insert_filter_scan.sv @@
// ----------------------------------------------------------------------------
// Bitmap set with insert, filter and scan
// Set membership over a 2^HASH_BITS hash space kept in one bitmap memory.
// ----------------------------------------------------------------------------
// Timing: the word of an accepted transaction is read from the bitmap memory
//   into rdata_r and acted on in ST_LOOK; a filter result or the scan hashes
//   then pass from ST_EMIT to the output register, one a cycle unless stalled.
// Busy: input waits until ST_IDLE; an insert, a present filter, an empty scan
//   or an unused command returns there after the read, others after the last hash.
// Reset: the bitmap is cleared by a pass over all WORD_COUNT (16384) words, one
//   word per cycle, during which no input transaction is accepted.
// ----------------------------------------------------------------------------
module bitmap_set_insert_filter_scan
  import bsifs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [1:0] command, [21:2] hash_value,
                                             // [35:22] word_index, rest zero
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [19:0] out_hash, rest zero
  output logic                   out_tlast
);

  // The bitmap itself: one write port, one read port with registered data.
  logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rdata_r;

  logic                 mem_we;
  logic [WIDX_BITS-1:0] mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WIDX_BITS-1:0] mem_raddr;

  // Control state.
  state_t               state_r, state_nxt;
  logic [WIDX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;

  // The transaction being worked on.
  cmd_t                 cmd_r, cmd_nxt;
  logic [WIDX_BITS-1:0] base_r, base_nxt;
  logic [OFF_BITS-1:0]  off_r, off_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;

  // Output register, which decouples the result channel from the work.
  logic                 out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0]    out_hash_r, out_hash_nxt;
  logic                 out_last_r, out_last_nxt;

  // Input field decode.
  logic                 in_accept;
  cmd_t                 in_cmd;
  logic [HASH_BITS-1:0] in_hash;
  logic [WIDX_BITS-1:0] in_widx;

  // Emit path.
  logic [OFF_BITS-1:0]  lead_off;
  logic [WORD_BITS-1:0] word_clr;
  logic                 out_load;

  // Offset of the first set bit, counting from bit 63 as offset 0.
  function automatic logic [OFF_BITS-1:0] lead_one(input logic [WORD_BITS-1:0] w);
    logic [OFF_BITS-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[WORD_BITS-1-i]) begin
        pos = OFF_BITS'(i);
      end
    end
    return pos;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tdata[CMD_LSB +: CMD_W]);
  assign in_hash   = HASH_BITS'(in_tdata[HASH_LSB +: HASH_W]);
  assign in_widx   = WIDX_BITS'(in_tdata[WIDX_LSB +: WIDX_W]);

  assign lead_off  = lead_one(word_r);
  assign word_clr  = word_r & ~(TOP_BIT >> lead_off);

  // A result leaves the work only when the output register is free or
  // being emptied in this very cycle.
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = (word_nxt != '0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load && (word_clr == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory accesses, datapath and output register loading.
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = base_r;
    mem_wdata     = rdata_r;
    mem_re        = 1'b0;
    mem_raddr     = in_widx;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    base_nxt      = base_r;
    off_nxt       = off_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_hash_nxt  = out_hash_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        // Scan reads the given word; insert and filter read the hash's word.
        if (in_accept) begin
          mem_re    = 1'b1;
          mem_raddr = (in_cmd == CMD_SCAN) ? in_widx : in_hash[HASH_BITS-1:OFF_BITS];
          cmd_nxt   = in_cmd;
          base_nxt  = mem_raddr;
          off_nxt   = in_hash[OFF_BITS-1:0];
        end
      end
      ST_LOOK: begin
        // The word read is in rdata_r; act on it according to the command.
        case (cmd_r)
          CMD_INSERT: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_r | (TOP_BIT >> off_r);
            word_nxt  = '0;
          end
          CMD_FILTER: begin
            // A clear bit becomes the single bit to emit.
            word_nxt = ((rdata_r & (TOP_BIT >> off_r)) != '0) ? '0 : (TOP_BIT >> off_r);
          end
          CMD_SCAN: begin
            word_nxt = rdata_r;
          end
          default: begin
            word_nxt = '0;
          end
        endcase
      end
      ST_EMIT: begin
        if (out_load) begin
          word_nxt      = word_clr;
          out_valid_nxt = 1'b1;
          out_hash_nxt  = HASH_W'({base_r, lead_off});
          out_last_nxt  = (word_clr == '0);
        end
      end
      default: begin
        word_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= bitmap_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    base_r     <= base_nxt;
    off_r      <= off_nxt;
    word_r     <= word_nxt;
    out_hash_r <= out_hash_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_hash_r);
  assign out_tlast  = out_last_r;

endmodule

@@ src/bsifs_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap set port checker
// Concurrent checks on the ports of the bitmap set block, bound to it.
// ----------------------------------------------------------------------------
`include "bitmap_set_insert_filter_scan_defines.svh"

module bsifs_checker
  import bsifs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A stalled result holds its data and its last flag.
  `BSIFS_ASSERT_RST(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Reset empties the output register.
  `BSIFS_ASSERT(a_rst_out, !rst_n |=> !out_tvalid, "result valid after reset")

  // Reset starts the clearing pass, which takes no input.
  `BSIFS_ASSERT(a_rst_in, !rst_n |=> !in_tready, "input ready during clearing pass")

  // The block never takes input in the cycle after it took a transaction.
  `BSIFS_ASSERT_RST(a_busy, in_tvalid && in_tready |=> !in_tready, "input taken on back-to-back cycles")

  // The padding above the hash is always zero.
  `BSIFS_ASSERT_RST(a_pad, out_tvalid |-> out_tdata[OUT_TDATA_W-1:HASH_W] == '0, "tdata padding not zero")

endmodule

bind bitmap_set_insert_filter_scan bsifs_checker u_checker (.*);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the bitmap set block
// Drives insert, filter and scan transactions, keeps its own copy of the
// membership bitmap, and checks every hash that the block returns, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bsifs_pkg::*;

  // The command field can carry a code that the block has no operation for.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Each side idles in about this many cycles of a hundred.
  localparam int GAP_PERCENT = 16;

  // The clearing pass after reset accepts nothing until all WORD_COUNT words are
  // cleared, so the watchdog limit must comfortably outlast it.
  localparam int WATCHDOG_LIMIT = 60000;

  // One hash that the block is expected to return, with its last flag.
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic              last;
  } hash_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [1:0] command, [21:2] hash_value,
                                             // [35:22] word_index, rest zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [19:0] out_hash, rest zero
  logic                   out_tlast;

  // Our own copy of the set. Bit 63 of a word stands for offset 0.
  bit [WORD_BITS-1:0] set_words [WORD_COUNT];

  // Hashes still owed by the block, oldest first.
  hash_result_t expected_hashes [$];

  // A handful of words that the random part keeps returning to, so that the
  // scans find something to report.
  logic [WIDX_W-1:0] hot_words [4];

  bit no_gaps      = 1'b0;
  int fail_count   = 0;
  int quiet_cycles = 0;

  bitmap_set_insert_filter_scan uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Applies one accepted command to the shadow bitmap and queues the hashes
  // that it should produce. Insert and the unused code never produce
  // anything; a filter reports its hash only when the bit is clear; a scan
  // reports every set bit of its word from offset 0 upwards.
  function automatic void predict_set_command(input logic [CMD_W-1:0]  cmd,
                                              input logic [HASH_W-1:0] hash,
                                              input logic [WIDX_W-1:0] widx);
    logic [WIDX_W-1:0]    hash_word;
    logic [WORD_BITS-1:0] hash_bit;
    logic [WORD_BITS-1:0] scanned;
    int                   remaining;
    hash_result_t         owed;
    hash_word = hash[HASH_W-1:OFF_BITS];
    hash_bit  = TOP_BIT >> hash[OFF_BITS-1:0];
    case (cmd)
      CMD_INSERT: begin
        set_words[hash_word] |= hash_bit;
      end
      CMD_FILTER: begin
        if ((set_words[hash_word] & hash_bit) == '0) begin
          owed.hash       = hash;
          owed.last       = 1'b1;
          expected_hashes = {expected_hashes, owed};
        end
      end
      CMD_SCAN: begin
        scanned   = set_words[widx];
        remaining = $countones(scanned);
        for (int off = 0; off < WORD_BITS; off++) begin
          if (scanned[WORD_BITS-1-off]) begin
            remaining--;
            owed.hash       = {widx, OFF_BITS'(off)};
            owed.last       = (remaining == 0);
            expected_hashes = {expected_hashes, owed};
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one transaction and returns at the edge where it is accepted,
  // leaving tvalid high. The caller either sends the next one straight away
  // or lowers tvalid with stop_sending in the same time step.
  task automatic send_item(input logic [CMD_W-1:0]  cmd,
                           input logic [HASH_W-1:0] hash,
                           input logic [WIDX_W-1:0] widx);
    while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, widx, hash, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_set_command(cmd, hash, widx);
  endtask

  // Lowers tvalid and waits for the next clock edge, so that the next transaction
  // is offered in a later time step.
  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until the block has returned everything that it owes.
  task automatic wait_until_drained();
    while (expected_hashes.size() != 0) @(posedge clk);
  endtask

  // A random hash somewhere inside the given word.
  function automatic logic [HASH_W-1:0] hash_in_word(input logic [WIDX_W-1:0] widx);
    return {widx, OFF_BITS'($urandom_range(WORD_BITS-1))};
  endfunction

  // One random command, mostly aimed at the hot words so that filters hit
  // present bits and scans have something to report. The rest is noise:
  // hashes anywhere, scans of words that are most likely empty, and the
  // unused command code. Ignored fields always carry random bits.
  task automatic send_random_op();
    int                r;
    logic [WIDX_W-1:0] hot;
    logic [HASH_W-1:0] junk_hash;
    logic [WIDX_W-1:0] junk_widx;
    r         = $urandom_range(99);
    hot       = hot_words[$urandom_range(3)];
    junk_hash = HASH_W'($urandom);
    junk_widx = WIDX_W'($urandom);
    if (r < 35)
      send_item(CMD_INSERT, hash_in_word(hot), junk_widx);
    else if (r < 60)
      send_item(CMD_FILTER, hash_in_word(hot), junk_widx);
    else if (r < 75)
      send_item(CMD_SCAN, junk_hash, hot);
    else if (r < 80)
      send_item(CMD_INSERT, HASH_W'($urandom), junk_widx);
    else if (r < 88)
      send_item(CMD_FILTER, HASH_W'($urandom), junk_widx);
    else if (r < 95)
      send_item(CMD_SCAN, junk_hash, WIDX_W'($urandom));
    else
      send_item(CMD_UNUSED, junk_hash, junk_widx);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Drives out_tready with random stalls and compares each accepted result
  // with the oldest expectation. The padding bits of tdata must be zero, so
  // the whole bus is compared against the zero-extended hash.
  always @(posedge clk) begin : result_checker
    hash_result_t want;
    out_tready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hashes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual hash %h last %b",
                 $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = expected_hashes.pop_front();
        if (out_tdata !== OUT_TDATA_W'(want.hash)) begin
          $display("%0t: hash mismatch: expected %h, actual %h",
                   $time, OUT_TDATA_W'(want.hash), out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last mismatch on hash %h: expected %b, actual %b",
                   $time, want.hash, want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Counts cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes of the hash space, duplicate inserts, filters of present and
  // absent hashes, scans of the first, the last and an empty word, and the
  // unused command code, which must neither set a bit nor report anything.
  task automatic directed_extremes_test();
    send_item(CMD_INSERT, '0, '1);
    send_item(CMD_INSERT, '1, '1);
    send_item(CMD_INSERT, '0, '0);
    send_item(CMD_FILTER, '0, '1);
    send_item(CMD_FILTER, '1, '0);
    send_item(CMD_FILTER, HASH_W'(1), '1);
    send_item(CMD_FILTER, HASH_W'(20'hFFFFE), '0);
    send_item(CMD_INSERT, HASH_W'(1), '0);
    send_item(CMD_INSERT, HASH_W'(63), '0);
    send_item(CMD_SCAN, '1, '0);
    send_item(CMD_SCAN, '0, '1);
    send_item(CMD_SCAN, '1, WIDX_W'(5));
    send_item(CMD_UNUSED, HASH_W'(2), '0);
    send_item(CMD_UNUSED, '1, '1);
    send_item(CMD_FILTER, HASH_W'(2), '0);
    send_item(CMD_SCAN, '0, '0);
    send_item(CMD_INSERT, HASH_W'(64), WIDX_W'(5));
    send_item(CMD_SCAN, HASH_W'(63), WIDX_W'(1));
    send_item(CMD_FILTER, HASH_W'(63), '1);
    send_item(CMD_FILTER, HASH_W'(127), '0);
    stop_sending();
  endtask

  // Fills one word completely in a shuffled order and scans it, so that a
  // single scan returns all 64 hashes with only the final one marked.
  task automatic full_word_test();
    logic [WIDX_W-1:0] widx;
    int                order [WORD_BITS];
    int                pick;
    int                swap;
    widx = WIDX_W'($urandom);
    for (int i = 0; i < WORD_BITS; i++) order[i] = i;
    for (int i = WORD_BITS - 1; i > 0; i--) begin
      pick        = $urandom_range(i);
      swap        = order[i];
      order[i]    = order[pick];
      order[pick] = swap;
    end
    for (int i = 0; i < WORD_BITS; i++)
      send_item(CMD_INSERT, {widx, OFF_BITS'(order[i])}, WIDX_W'($urandom));
    send_item(CMD_SCAN, HASH_W'($urandom), widx);
    send_item(CMD_FILTER, hash_in_word(widx), WIDX_W'($urandom));
    send_item(CMD_SCAN, HASH_W'($urandom), widx);
    stop_sending();
  endtask

  task automatic random_mix_test();
    for (int i = 0; i < 4; i++) hot_words[i] = WIDX_W'($urandom);
    for (int i = 0; i < 80; i++) send_random_op();
    stop_sending();
  endtask

  // The same mix with both sides permanently ready, so that transactions follow
  // one another with no idle gaps for a long stretch.
  task automatic back_to_back_test();
    no_gaps = 1'b1;
    for (int i = 0; i < 30; i++) send_random_op();
    stop_sending();
    wait_until_drained();
    no_gaps = 1'b0;
  endtask

  // The sender holds off until every owed hash has arrived, then checks that
  // inserts made before the pause are still visible after it.
  task automatic drain_pause_test();
    logic [WIDX_W-1:0] widx;
    widx = WIDX_W'($urandom);
    for (int i = 0; i < 6; i++)
      send_item(CMD_INSERT, hash_in_word(widx), WIDX_W'($urandom));
    send_item(CMD_SCAN, HASH_W'($urandom), hot_words[0]);
    send_item(CMD_FILTER, hash_in_word(widx), WIDX_W'($urandom));
    stop_sending();
    wait_until_drained();
    send_item(CMD_SCAN, HASH_W'($urandom), widx);
    send_item(CMD_FILTER, hash_in_word(widx), WIDX_W'($urandom));
    send_item(CMD_SCAN, HASH_W'($urandom), hot_words[1]);
    stop_sending();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  // Reset is held at the start. After it the block clears its bitmap one
  // word per cycle and keeps in_tready low; the first transaction simply
  // waits for it.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    directed_extremes_test();
    full_word_test();
    random_mix_test();
    back_to_back_test();
    drain_pause_test();
    wait_until_drained();
    // A few more cycles so that a stray extra result would still be caught.
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ bitmap_set_insert_filter_scan.f @@
+incdir+src
src/bsifs_pkg.sv
src/bitmap_set_insert_filter_scan.sv
src/bsifs_checker.sv
bench/tb_top.sv
